>>> design/mms_pkg.sv
// Shared types, constants and codes for the magic multiplier search block.
package mms_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int BITS_W = 4;
  localparam int CNT_W = ADDR_W + 1;

  localparam logic [31:0] RNG_SEED = 32'd1804289383;
  localparam int MIN_TOP_BITS = 6;

  localparam logic [BITS_W-1:0] BITS_CAP = BITS_W'(ADDR_W);
  localparam logic [BITS_W-1:0] BITS_RESET = 4'd12;

  localparam logic [1:0] CFG_BITS = 2'd0;
  localparam logic [1:0] CFG_MASK = 2'd1;
  localparam logic [1:0] CFG_TRIES = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [1:0] MUL_LO_LO = 2'd0;
  localparam logic [1:0] MUL_LO_HI = 2'd1;
  localparam logic [1:0] MUL_HI_LO = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [63:0] occupancy;
    logic [63:0] attack;
  } in_item_t;

  typedef struct packed {
    logic [63:0] magic;
    logic        found;
    logic [31:0] tries_used;
  } out_item_t;

  typedef struct packed {
    logic       load_wr;
    logic       srch_start;
    logic       draw_init;
    logic       draw_step;
    logic       draw_word_end;
    logic       count_inc;
    logic       mul_issue;
    logic       mul_sel_mask;
    logic [1:0] mul_step;
    logic       clear_wr;
    logic       idx_clr;
    logic       idx_inc;
    logic       store_rd;
    logic       hash_rd;
    logic       hash_wr;
    logic       res_load;
    logic       res_found;
  } mms_cmd_t;

  typedef struct packed {
    logic top_ok;
    logic tries_done;
    logic idx_last;
    logic hash_empty;
    logic hash_match;
    logic out_busy;
  } mms_sts_t;

endpackage

>>> design/magic_multiplier_search_core.sv
// Top level of the magic multiplier search block.
//
// Input channel (in_valid/in_ready, in_item): a load item (opcode 0) writes
// one occupancy/attack pair at the next store position, wrapping at
// 2^key_bits with key_bits clamped to 1..12; it gives no result. A search
// item (opcode 1) draws candidates until one hashes every stored pair
// without conflict or max_tries candidates are spent, then gives one result
// on the output channel (out_valid/out_ready, out_item).
// Per candidate: check the try limit, draw, form the mask product and
// screen. A screened-in candidate clears the table, then for each stored
// pair does a store read, three 32x32 partial products through the single
// multiplier, a table read and a check. Load items follow each other every
// cycle; a search holds the input until its result is registered.
// Reset returns the random state to its seed, the load position to zero and
// the registers to their defaults; stores hold no defined contents.
// The result waits in an output register; a stalled receiver lets loads
// through and holds a finished search until the register is free.
module magic_multiplier_search_core
  import mms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  mms_cmd_t cmd;
  mms_sts_t sts;

  mms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_item.opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  mms_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> design/mms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/mms_dp.sv
// Datapath: configuration, stores, hash table, random source, multiplier and result.
module mms_dp
  import mms_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  in_item_t          in_item,
  input  mms_cmd_t          cmd,
  output mms_sts_t          sts,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item
);

  logic [BITS_W-1:0] key_bits;
  logic [63:0]       screen_mask;
  logic [31:0]       max_tries;

  logic [BITS_W-1:0] eff_bits;
  logic [ADDR_W-1:0] n_mask;
  logic [ADDR_W-1:0] load_pos;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] slot;

  logic [31:0] rng;
  logic [31:0] rng_next;
  logic [63:0] word;
  logic [63:0] word_next;
  logic [63:0] cand;
  logic [31:0] try_count;

  logic [63:0] mul_a;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;
  logic [1:0]  pstep;
  logic        pvalid;
  logic [63:0] acc;

  logic [127:0] st_rdata;
  logic [63:0]  st_occ;
  logic [63:0]  st_att;
  logic [63:0]  h_rdata;
  logic         h_we;
  logic [ADDR_W-1:0] h_waddr;
  logic [63:0]  h_wdata;
  logic [5:0]   shamt;
  logic [31:0]  shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bits <= BITS_RESET;
      screen_mask <= 64'd0;
      max_tries <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BITS: key_bits <= cfg_data[BITS_W-1:0];
        CFG_MASK: screen_mask <= cfg_data;
        CFG_TRIES: max_tries <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (key_bits == '0) begin
      eff_bits = BITS_W'(1);
    end else if (key_bits > BITS_CAP) begin
      eff_bits = BITS_CAP;
    end else begin
      eff_bits = key_bits;
    end
    n_mask = ADDR_W'((CNT_W'(1) << eff_bits) - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
    end else if (cmd.load_wr) begin
      load_pos <= (load_pos + ADDR_W'(1)) & n_mask;
    end
  end

  mms_ram #(.WIDTH(128), .DEPTH(MAX_ENTRIES)) u_store (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (load_pos & n_mask),
    .wdata ({in_item.occupancy, in_item.attack}),
    .re    (cmd.store_rd),
    .raddr (idx),
    .rdata (st_rdata)
  );

  assign st_occ = st_rdata[127:64];
  assign st_att = st_rdata[63:0];

  always_comb begin
    rng_next = rng ^ (rng << 13);
    rng_next = rng_next ^ (rng_next >> 17);
    rng_next = rng_next ^ (rng_next << 5);
    word_next = {rng_next[15:0], word[63:16]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rng <= RNG_SEED;
    end else if (cmd.draw_step) begin
      rng <= rng_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_init) begin
      cand <= '1;
    end else if (cmd.draw_step && cmd.draw_word_end) begin
      cand <= cand & word_next;
    end
    if (cmd.draw_step) begin
      word <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      try_count <= '0;
    end else if (cmd.srch_start) begin
      try_count <= '0;
    end else if (cmd.count_inc) begin
      try_count <= try_count + 32'd1;
    end
  end

  always_comb begin
    mul_a = cmd.mul_sel_mask ? screen_mask : st_occ;
    case (cmd.mul_step)
      MUL_LO_LO: begin
        op_a = mul_a[31:0];
        op_b = cand[31:0];
      end
      MUL_LO_HI: begin
        op_a = mul_a[31:0];
        op_b = cand[63:32];
      end
      MUL_HI_LO: begin
        op_a = mul_a[63:32];
        op_b = cand[31:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= cmd.mul_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_issue) begin
      prod <= 64'(op_a) * 64'(op_b);
      pstep <= cmd.mul_step;
    end
    if (pvalid) begin
      if (pstep == MUL_LO_LO) begin
        acc <= prod;
      end else begin
        acc[63:32] <= acc[63:32] + prod[31:0];
      end
    end
  end

  always_comb begin
    shamt = 6'd32 - {2'b00, eff_bits};
    shifted = acc[63:32] >> shamt;
    slot = shifted[ADDR_W-1:0] & n_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + ADDR_W'(1);
    end
  end

  assign h_we = cmd.clear_wr | cmd.hash_wr;
  assign h_waddr = cmd.clear_wr ? idx : slot;
  assign h_wdata = cmd.clear_wr ? 64'd0 : st_att;

  mms_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_hash (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (cmd.hash_rd),
    .raddr (slot),
    .rdata (h_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_item.magic <= cmd.res_found ? cand : 64'd0;
      out_item.found <= cmd.res_found;
      out_item.tries_used <= try_count;
    end
  end

  always_comb begin
    sts.top_ok = $countones(acc[63:56]) >= MIN_TOP_BITS;
    sts.tries_done = try_count >= max_tries;
    sts.idx_last = idx == n_mask;
    sts.hash_empty = h_rdata == 64'd0;
    sts.hash_match = h_rdata == st_att;
    sts.out_busy = out_valid & ~out_ready;
  end

endmodule

>>> design/mms_ctrl.sv
// Controller: sequences loads, candidate draws, screening and table trials.
module mms_ctrl
  import mms_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_opcode,
  input  mms_sts_t sts,
  output mms_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TRY   = 4'd1;
  localparam logic [3:0] S_DRAW  = 4'd2;
  localparam logic [3:0] S_MMUL  = 4'd3;
  localparam logic [3:0] S_MCHK  = 4'd4;
  localparam logic [3:0] S_CLEAR = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_EMUL  = 4'd7;
  localparam logic [3:0] S_HRD   = 4'd8;
  localparam logic [3:0] S_HCHK  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] cnt;
  logic [3:0] cnt_next;
  logic       found;
  logic       found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      found <= found_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    found_next = found;
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_SEARCH) begin
            cmd.srch_start = 1'b1;
            state_next = S_TRY;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_TRY: begin
        if (sts.tries_done) begin
          found_next = 1'b0;
          state_next = S_DONE;
        end else begin
          cmd.draw_init = 1'b1;
          cnt_next = '0;
          state_next = S_DRAW;
        end
      end
      S_DRAW: begin
        cmd.draw_step = 1'b1;
        cmd.draw_word_end = cnt[1:0] == 2'd3;
        if (cnt == 4'd11) begin
          cmd.count_inc = 1'b1;
          cnt_next = '0;
          state_next = S_MMUL;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      S_MMUL, S_EMUL: begin
        cmd.mul_sel_mask = state == S_MMUL;
        cmd.mul_step = cnt[1:0];
        cmd.mul_issue = cnt != 4'd3;
        if (cnt == 4'd3) begin
          cnt_next = '0;
          state_next = (state == S_MMUL) ? S_MCHK : S_HRD;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      S_MCHK: begin
        if (sts.top_ok) begin
          cmd.idx_clr = 1'b1;
          state_next = S_CLEAR;
        end else begin
          state_next = S_TRY;
        end
      end
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next = S_RD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_RD: begin
        cmd.store_rd = 1'b1;
        cnt_next = '0;
        state_next = S_EMUL;
      end
      S_HRD: begin
        cmd.hash_rd = 1'b1;
        state_next = S_HCHK;
      end
      S_HCHK: begin
        cmd.hash_wr = sts.hash_empty;
        if (!sts.hash_empty && !sts.hash_match) begin
          state_next = S_TRY;
        end else if (sts.idx_last) begin
          found_next = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_RD;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          cmd.res_found = found;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/mms_chk.sv
// Port-level checker for the magic multiplier search block, with its bind.
module mms_chk
  import mms_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.found |-> out_item.magic == 64'd0)
    else $error("failed search reports a non-zero magic");

  a_found_tries: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.found |-> out_item.tries_used != 32'd0)
    else $error("success reported with no candidate drawn");

  a_search_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.opcode == OP_SEARCH |=> !in_ready)
    else $error("input taken while a search runs");

endmodule

bind magic_multiplier_search_core mms_chk u_mms_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

>>> test/tb_top.sv
// Testbench for the magic multiplier search core: directed table, then random phases.
`timescale 1ns / 1ps
module tb_top;
  import mms_pkg::*;

  localparam int LIMIT = 6000000;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [63:0] data;
    in_item_t    item;
    logic        typed;
    out_item_t   exp;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;

  magic_multiplier_search_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  // predictor state
  logic [63:0] occ_mem [MAX_ENTRIES];
  logic [63:0] att_mem [MAX_ENTRIES];
  logic [63:0] slot_mem [MAX_ENTRIES];
  bit          written [MAX_ENTRIES];
  logic [31:0] rng_q;
  logic [11:0] load_pos;
  logic [3:0]  bits_q;
  logic [63:0] mask_q;
  logic [31:0] tries_q;

  out_item_t   search_results [$];
  int          errors;
  int          cycles;
  int          in_idle;
  int          out_stall;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (search_results.size() == 0) begin
        $display("%t: result with none expected: %h", $realtime, out_item);
        errors++;
      end else begin
        want = search_results.pop_front();
        if (out_item.magic !== want.magic) begin
          $display("%t: magic exp %h got %h", $realtime, want.magic, out_item.magic);
          errors++;
        end
        if (out_item.found !== want.found) begin
          $display("%t: found exp %b got %b", $realtime, want.found, out_item.found);
          errors++;
        end
        if (out_item.tries_used !== want.tries_used) begin
          $display("%t: tries_used exp %0d got %0d", $realtime, want.tries_used,
                   out_item.tries_used);
          errors++;
        end
      end
    end
  end

  function automatic int eff_bits();
    int b;
    b = bits_q;
    if (b < 1) b = 1;
    if (b > 12) b = 12;
    return b;
  endfunction

  function automatic logic [31:0] rng_advance();
    logic [31:0] x;
    x = rng_q;
    x ^= x << 13;
    x ^= x >> 17;
    x ^= x << 5;
    rng_q = x;
    return x;
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    logic [31:0] r;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      r = rng_advance();
      w[16*k +: 16] = r[15:0];
    end
    return w;
  endfunction

  function automatic bit hashes_clean(logic [63:0] cand, int b);
    int n;
    logic [63:0] prod;
    int s;
    n = 1 << b;
    for (int i = 0; i < n; i++) slot_mem[i] = '0;
    for (int i = 0; i < n; i++) begin
      prod = occ_mem[i] * cand;
      s = int'(prod >> (64 - b)) & (n - 1);
      if (slot_mem[s] == 0) slot_mem[s] = att_mem[i];
      else if (slot_mem[s] != att_mem[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic out_item_t search_outcome();
    out_item_t r;
    logic [31:0] cnt;
    logic [63:0] cand;
    logic [63:0] top;
    r = '0;
    cnt = '0;
    while (cnt < tries_q) begin
      cand = rand_word() & rand_word() & rand_word();
      cnt++;
      top = (mask_q * cand) & 64'hFF00000000000000;
      if ($countones(top) < MIN_TOP_BITS) continue;
      if (hashes_clean(cand, eff_bits())) begin
        r.magic = cand;
        r.found = 1'b1;
        break;
      end
    end
    r.tries_used = cnt;
    return r;
  endfunction

  function automatic bit store_full();
    for (int i = 0; i < (1 << eff_bits()); i++) if (!written[i]) return 1'b0;
    return 1'b1;
  endfunction

  // advance the predictor for one accepted item
  function automatic void absorb(in_item_t it, bit typed, out_item_t exp);
    int n;
    int p;
    out_item_t r;
    n = 1 << eff_bits();
    if (it.opcode == OP_LOAD) begin
      p = load_pos & (n - 1);
      occ_mem[p] = it.occupancy;
      att_mem[p] = it.attack;
      written[p] = 1'b1;
      load_pos = 12'((p + 1) & (n - 1));
    end else begin
      r = search_outcome();
      search_results.push_back(typed ? exp : r);
    end
  endfunction

  task automatic send(in_item_t it, bit typed = 1'b0, out_item_t exp = '0);
    while ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    absorb(it, typed, exp);
  endtask

  // hold until the block is idle, then write one register
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (search_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BITS: bits_q = val[3:0];
      CFG_MASK: mask_q = val;
      CFG_TRIES: tries_q = val[31:0];
      default: ;
    endcase
  endtask

  function automatic in_item_t load_of(logic [63:0] o, logic [63:0] a);
    in_item_t it;
    it.opcode = OP_LOAD;
    it.occupancy = o;
    it.attack = a;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_attack();
    case ($urandom_range(5))
      0: return 64'h0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return 64'h0000_0000_0000_0081;
      3: return 64'h0102_0408_1020_4080;
      default: return rand64();
    endcase
  endfunction

  function automatic row_t cfg_row(logic [1:0] idx, logic [63:0] val);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = val;
    return r;
  endfunction

  function automatic row_t item_row(in_item_t it, bit typed, out_item_t exp);
    row_t r;
    r = '0;
    r.item = it;
    r.typed = typed;
    r.exp = exp;
    return r;
  endfunction

  row_t        plan [$];
  in_item_t    srch;
  logic [63:0] ones;

  initial begin
    int mode;
    int count;
    int lo;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    in_idle = 0;
    out_stall = 0;
    rng_q = RNG_SEED;
    load_pos = '0;
    bits_q = BITS_RESET;
    mask_q = '0;
    tries_q = 32'hFFFF_FFFF;
    for (int i = 0; i < MAX_ENTRIES; i++) written[i] = 1'b0;
    ones = 64'hFFFF_FFFF_FFFF_FFFF;
    srch = '0;
    srch.opcode = OP_SEARCH;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plan.push_back(cfg_row(CFG_BITS, 64'd0));
    plan.push_back(cfg_row(CFG_MASK, ones));
    plan.push_back(cfg_row(CFG_TRIES, 64'd0));
    plan.push_back(item_row(load_of(64'h0, ones), 1'b0, '0));
    plan.push_back(item_row(load_of(ones, 64'h0), 1'b0, '0));
    plan.push_back(item_row(srch, 1'b1, '0));
    plan.push_back(cfg_row(CFG_TRIES, 64'hFFFF_FFFF));
    plan.push_back(item_row(load_of(64'h8000_0000_0000_0001, 64'h55), 1'b0, '0));
    plan.push_back(item_row(load_of(64'h0000_0000_FFFF_0000, 64'h55), 1'b0, '0));
    plan.push_back(item_row(srch, 1'b0, '0));
    plan.push_back(item_row(load_of(64'h1234_5678_9ABC_DEF0, 64'h0), 1'b0, '0));
    plan.push_back(item_row(srch, 1'b0, '0));
    plan.push_back(cfg_row(CFG_MASK, 64'h0));
    plan.push_back(cfg_row(CFG_TRIES, 64'd5));
    plan.push_back(item_row(srch, 1'b1, '{magic: 64'h0, found: 1'b0, tries_used: 32'd5}));
    plan.push_back(cfg_row(CFG_BITS, 64'd15));
    plan.push_back(item_row(load_of(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555),
                            1'b0, '0));
    plan.push_back(cfg_row(CFG_BITS, 64'd2));
    plan.push_back(cfg_row(CFG_MASK, 64'h0000_0000_0000_0101));
    plan.push_back(cfg_row(CFG_TRIES, 64'd1));
    for (int i = 0; i < 4; i++) plan.push_back(item_row(load_of(rand64(), 64'h7), 1'b0, '0));
    plan.push_back(item_row(srch, 1'b0, '0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
      else send(plan[i].item, plan[i].typed, plan[i].exp);
    end

    for (int ph = 0; ph < 9; ph++) begin
      mode = ph % 4;
      in_idle = (mode == 1) ? 55 : (mode == 3) ? 32 : 0;
      out_stall = (mode == 2) ? 55 : (mode == 3) ? 32 : 0;
      if (ph == 6) begin
        write_reg(CFG_BITS, 64'd9);
        write_reg(CFG_MASK, ones);
        write_reg(CFG_TRIES, 64'd3);
        for (int i = 0; i < 512; i++) send(load_of(rand64(), pick_attack()));
        send(srch);
        continue;
      end
      write_reg(CFG_BITS, 64'($urandom_range(5)));
      case ($urandom_range(3))
        0: write_reg(CFG_MASK, ones);
        1: write_reg(CFG_MASK, 64'h0);
        2: write_reg(CFG_MASK, rand64() | 64'h00FF_0000_0000_0000);
        default: write_reg(CFG_MASK, rand64());
      endcase
      write_reg(CFG_TRIES, 64'($urandom_range(40, 1)));
      lo = $urandom_range(3);
      for (int k = 0; k < 90; k++) begin
        if (store_full() && $urandom_range(99) < 20) begin
          send(srch);
        end else begin
          count = $urandom_range(3);
          send(load_of(rand64(), (count == 0) ? pick_attack() : 64'(lo + count)));
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (search_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mms_pkg.sv
design/mms_ram.sv
design/mms_dp.sv
design/mms_ctrl.sv
design/magic_multiplier_search_core.sv
design/mms_chk.sv
test/tb_top.sv
